// File: design/change_record_table_top_assert.svh
// Assertion macros for the change record table.
`ifndef CHANGE_RECORD_TABLE_TOP_ASSERT_SVH
`define CHANGE_RECORD_TABLE_TOP_ASSERT_SVH

// Holds at every edge outside reset.
`define CRT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Holds in the cycle after the trigger.
`define CRT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

// File: design/crt_pkg.sv
`default_nettype none

package crt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_WIDTH   = 32;
    localparam int TAG_W       = 32;
    localparam int REV_W       = 32;
    localparam int CNT_OUT_W   = 7;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_DELETE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ARG   = 2'd1,
        ST_BAD_STATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] entity_key;
        logic [KEY_WIDTH-1:0] field_key;
        logic [TAG_W-1:0]     change_tag;
        t_kind                change_kind;
    } t_in_word;

    typedef struct packed {
        t_status              status;
        logic [REV_W-1:0]     revision_now;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [CNT_OUT_W-1:0] insert_total;
        logic [CNT_OUT_W-1:0] update_total;
        logic [CNT_OUT_W-1:0] delete_total;
    } t_out_word;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] entity;
        logic [KEY_WIDTH-1:0] field;
        logic [TAG_W-1:0]     tag;
        t_kind                kind;
        logic [REV_W-1:0]     revision;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_APPEND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: design/crt_ram.sv
`default_nettype none

module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/change_record_table_top.sv
// Channel | Direction | Handshake                | Word
// in      | input     | i_in_valid / o_in_ready  | i_in_word  (t_in_word)
// out     | output    | o_out_valid / i_out_ready| o_out_word (t_out_word)
//
// One change at a time. Kind none skips the scan; otherwise the table is
// scanned one entry per cycle from the entry RAM (single read port,
// registered read). An insert cancelled by a delete moves the last entry
// into its slot. Reset (synchronous, active low) empties the table and
// clears all counters; no clearing pass. The result sits in an output
// register, so a stalled output holds the next change only at its end.
`default_nettype none

`include "change_record_table_top_assert.svh"

module change_record_table_top
    import crt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_state               r_state, n_state;
    t_in_word             r_req, n_req;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_live, n_live;
    logic [CNT_W-1:0]     r_cnt_ins, n_cnt_ins;
    logic [CNT_W-1:0]     r_cnt_upd, n_cnt_upd;
    logic [CNT_W-1:0]     r_cnt_del, n_cnt_del;
    logic [REV_W-1:0]     r_rev, n_rev;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_word, n_out_word;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    t_entry               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               rd;

    logic [CNT_W-1:0]     w_idx_inc;
    logic [CNT_W-1:0]     w_last;
    logic                 w_hit;
    logic                 w_scan_end;
    logic                 w_full;
    logic                 w_reject;
    logic                 w_cancel;
    logic                 w_out_free;
    logic [REV_W-1:0]     w_rev_inc;

    assign rd         = t_entry'(ram_rdata);
    assign w_idx_inc  = CNT_W'(r_idx) + CNT_W'(1);
    assign w_last     = r_live - CNT_W'(1);
    assign w_hit      = (rd.entity == r_req.entity_key) && (rd.field == r_req.field_key);
    assign w_scan_end = (w_idx_inc == r_live);
    assign w_full     = (r_live == CNT_W'(TABLE_DEPTH));
    assign w_reject   = (rd.kind == KIND_DELETE) && (r_req.change_kind != KIND_INSERT);
    assign w_cancel   = (rd.kind == KIND_INSERT) && (r_req.change_kind == KIND_DELETE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_rev_inc  = r_rev + REV_W'(1);

    crt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_word.change_kind == KIND_NONE) begin
                        n_state = S_DONE;
                    end else if (r_live == '0) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (w_hit) begin
                    n_state = (w_cancel && !w_reject) ? S_MOVE_RD : S_DONE;
                end else if (w_scan_end) begin
                    n_state = S_APPEND;
                end
            end
            S_MOVE_RD: n_state = S_MOVE_WR;
            S_MOVE_WR: n_state = S_DONE;
            S_APPEND:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_idx       = r_idx;
        n_live      = r_live;
        n_cnt_ins   = r_cnt_ins;
        n_cnt_upd   = r_cnt_upd;
        n_cnt_del   = r_cnt_del;
        n_rev       = r_rev;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_raddr   = '0;
        ram_wdata   = rd;
        o_in_ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_req    = i_in_word;
                    n_idx    = '0;
                    n_status = (i_in_word.change_kind == KIND_NONE) ? ST_BAD_ARG : ST_OK;
                end
            end
            S_CMP: begin
                ram_raddr = w_idx_inc[IDX_W-1:0];
                if (w_hit) begin
                    if (w_reject) begin
                        n_status = ST_BAD_STATE;
                    end else if (!w_cancel) begin
                        ram_we             = 1'b1;
                        ram_wdata.kind     = r_req.change_kind;
                        ram_wdata.revision = w_rev_inc;
                        n_rev              = w_rev_inc;
                        n_cnt_ins = r_cnt_ins
                                  - CNT_W'(rd.kind == KIND_INSERT)
                                  + CNT_W'(r_req.change_kind == KIND_INSERT);
                        n_cnt_upd = r_cnt_upd
                                  - CNT_W'(rd.kind == KIND_UPDATE)
                                  + CNT_W'(r_req.change_kind == KIND_UPDATE);
                        n_cnt_del = r_cnt_del
                                  - CNT_W'(rd.kind == KIND_DELETE)
                                  + CNT_W'(r_req.change_kind == KIND_DELETE);
                    end
                end else if (!w_scan_end) begin
                    n_idx = w_idx_inc[IDX_W-1:0];
                end
            end
            S_MOVE_RD: begin
                ram_raddr = w_last[IDX_W-1:0];
            end
            S_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd;
                n_live    = w_last;
                n_rev     = w_rev_inc;
                n_cnt_ins = r_cnt_ins - CNT_W'(1);
            end
            S_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    ram_we             = 1'b1;
                    ram_waddr          = r_live[IDX_W-1:0];
                    ram_wdata.entity   = r_req.entity_key;
                    ram_wdata.field    = r_req.field_key;
                    ram_wdata.tag      = r_req.change_tag;
                    ram_wdata.kind     = r_req.change_kind;
                    ram_wdata.revision = w_rev_inc;
                    n_rev              = w_rev_inc;
                    n_live             = r_live + CNT_W'(1);
                    n_cnt_ins = r_cnt_ins + CNT_W'(r_req.change_kind == KIND_INSERT);
                    n_cnt_upd = r_cnt_upd + CNT_W'(r_req.change_kind == KIND_UPDATE);
                    n_cnt_del = r_cnt_del + CNT_W'(r_req.change_kind == KIND_DELETE);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_word.status       = r_status;
                    n_out_word.revision_now = r_rev;
                    n_out_word.entry_count  = CNT_OUT_W'(r_live);
                    n_out_word.insert_total = CNT_OUT_W'(r_cnt_ins);
                    n_out_word.update_total = CNT_OUT_W'(r_cnt_upd);
                    n_out_word.delete_total = CNT_OUT_W'(r_cnt_del);
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_cnt_ins   <= '0;
            r_cnt_upd   <= '0;
            r_cnt_del   <= '0;
            r_rev       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_cnt_ins   <= n_cnt_ins;
            r_cnt_upd   <= n_cnt_upd;
            r_cnt_del   <= n_cnt_del;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `CRT_ASSERT_NOW(a_live_bound, 1'b1, r_live <= CNT_W'(TABLE_DEPTH), "live count over depth")
    `CRT_ASSERT_NOW(a_kind_sum, 1'b1, (CNT_W+2)'(r_cnt_ins) + (CNT_W+2)'(r_cnt_upd) + (CNT_W+2)'(r_cnt_del) == (CNT_W+2)'(r_live), "kind counts do not sum to live count")
    `CRT_ASSERT_NOW(a_we_state, ram_we, r_state == S_CMP || r_state == S_MOVE_WR || r_state == S_APPEND, "entry write outside update states")
    `CRT_ASSERT_NEXT(a_rev_step, r_state != S_IDLE, r_rev == $past(r_rev) || r_rev == $past(r_rev) + REV_W'(1), "revision moved by more than one")

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

import crt_pkg::*;

class change_table_ledger;
    t_entry           rows[TABLE_DEPTH];
    int unsigned      live = 0;
    int unsigned      peak = 0;
    logic [REV_W-1:0] rev = '0;
    int unsigned      kind_cnt[3] = '{0, 0, 0};
    int unsigned      status_cnt[4] = '{0, 0, 0, 0};
    int unsigned      mismatches = 0;
    int unsigned      checked = 0;
    t_out_word        outcomes[$];

    function t_status apply(t_in_word w);
        t_kind old;
        if (w.change_kind == KIND_NONE) return ST_BAD_ARG;
        for (int i = 0; i < live; i++) begin
            if (rows[i].entity == w.entity_key && rows[i].field == w.field_key) begin
                old = rows[i].kind;
                if (old == KIND_DELETE && w.change_kind != KIND_INSERT) return ST_BAD_STATE;
                kind_cnt[int'(old) - 1]--;
                rev++;
                if (old == KIND_INSERT && w.change_kind == KIND_DELETE) begin
                    // insert cancelled by delete: last entry fills the hole
                    rows[i] = rows[live - 1];
                    live--;
                end else begin
                    rows[i].kind     = w.change_kind;
                    rows[i].revision = rev;
                    kind_cnt[int'(w.change_kind) - 1]++;
                end
                return ST_OK;
            end
        end
        if (live >= TABLE_DEPTH) return ST_FULL;
        rev++;
        rows[live] = '{entity: w.entity_key, field: w.field_key, tag: w.change_tag,
                       kind: w.change_kind, revision: rev};
        kind_cnt[int'(w.change_kind) - 1]++;
        live++;
        if (live > peak) peak = live;
        return ST_OK;
    endfunction

    function void note_change(t_in_word w);
        t_out_word o;
        o.status       = apply(w);
        o.revision_now = rev;
        o.entry_count  = CNT_OUT_W'(live);
        o.insert_total = CNT_OUT_W'(kind_cnt[0]);
        o.update_total = CNT_OUT_W'(kind_cnt[1]);
        o.delete_total = CNT_OUT_W'(kind_cnt[2]);
        status_cnt[o.status]++;
        outcomes.push_back(o);
    endfunction

    function void check_result(t_out_word got);
        t_out_word want;
        checked++;
        if (outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result word with nothing pending: %h", got);
            return;
        end
        want = outcomes.pop_front();
        if (got.status !== want.status || got.revision_now !== want.revision_now ||
            got.entry_count !== want.entry_count ||
            got.insert_total !== want.insert_total ||
            got.update_total !== want.update_total ||
            got.delete_total !== want.delete_total) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("word %0d mismatch (exp/got): status %0d/%0d rev %0d/%0d",
                         checked, want.status, got.status,
                         want.revision_now, got.revision_now);
                $display("    count %0d/%0d ins %0d/%0d upd %0d/%0d del %0d/%0d",
                         want.entry_count, got.entry_count,
                         want.insert_total, got.insert_total,
                         want.update_total, got.update_total,
                         want.delete_total, got.delete_total);
            end
        end
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    int                   in_gap_max;
    int                   out_gap_max;
    int unsigned          idle_cycles;
    logic [KEY_WIDTH-1:0] ent_pool[16];
    logic [KEY_WIDTH-1:0] fld_pool[16];

    change_table_ledger ledger = new();

    change_record_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_in_word change_word(logic [KEY_WIDTH-1:0] ent, logic [KEY_WIDTH-1:0] fld,
                                             logic [TAG_W-1:0] tag, t_kind kind);
        t_in_word w;
        w.entity_key  = ent;
        w.field_key   = fld;
        w.change_tag  = tag;
        w.change_kind = kind;
        return w;
    endfunction

    task automatic push_change(input t_in_word w);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ledger.note_change(w);
    endtask

    task automatic random_phase(int ent_n, int fld_n, int fresh_pct, int w_none, int w_ins,
                                int w_upd, int w_del, int in_max, int out_max, int n);
        t_in_word w;
        int       r;
        in_gap_max  = in_max;
        out_gap_max = out_max;
        repeat (n) begin
            w.entity_key = ($urandom_range(0, 99) < fresh_pct) ? KEY_WIDTH'($urandom)
                                                                : ent_pool[$urandom_range(0, ent_n - 1)];
            w.field_key  = ($urandom_range(0, 99) < fresh_pct) ? KEY_WIDTH'($urandom)
                                                                : fld_pool[$urandom_range(0, fld_n - 1)];
            w.change_tag = $urandom;
            r = $urandom_range(0, w_none + w_ins + w_upd + w_del - 1);
            if (r < w_none)                      w.change_kind = KIND_NONE;
            else if (r < w_none + w_ins)         w.change_kind = KIND_INSERT;
            else if (r < w_none + w_ins + w_upd) w.change_kind = KIND_UPDATE;
            else                                 w.change_kind = KIND_DELETE;
            push_change(w);
        end
    endtask

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, out_gap_max);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            ledger.check_result(o_out_word);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles without a transfer, %0d words pending",
                         idle_cycles, ledger.outcomes.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_WIDTH-1:0] z;
        logic [KEY_WIDTH-1:0] f;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        in_gap_max  = 12;
        out_gap_max = 12;
        z = '0;
        f = '1;
        foreach (ent_pool[k]) begin
            ent_pool[k] = $urandom;
            fld_pool[k] = $urandom;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        push_change(change_word(f, f, f, KIND_NONE));
        push_change(change_word(z, z, z, KIND_INSERT));
        push_change(change_word(f, f, f, KIND_INSERT));
        push_change(change_word(z, z, $urandom, KIND_UPDATE));
        push_change(change_word(z, z, $urandom, KIND_DELETE));
        push_change(change_word(z, z, $urandom, KIND_UPDATE));
        push_change(change_word(z, z, $urandom, KIND_DELETE));
        push_change(change_word(z, z, $urandom, KIND_NONE));
        push_change(change_word(z, z, $urandom, KIND_INSERT));
        push_change(change_word(ent_pool[0], fld_pool[0], $urandom, KIND_INSERT));
        push_change(change_word(ent_pool[0], fld_pool[1], $urandom, KIND_INSERT));
        push_change(change_word(ent_pool[1], fld_pool[0], $urandom, KIND_INSERT));
        // cancel in slot 0, last entry moves down
        push_change(change_word(z, z, $urandom, KIND_DELETE));
        push_change(change_word(ent_pool[1], fld_pool[0], $urandom, KIND_UPDATE));
        push_change(change_word(ent_pool[0], fld_pool[0], $urandom, KIND_INSERT));
        push_change(change_word(ent_pool[0], fld_pool[0], $urandom, KIND_DELETE));
        push_change(change_word(ent_pool[2], fld_pool[2], $urandom, KIND_DELETE));
        push_change(change_word(ent_pool[2], fld_pool[2], $urandom, KIND_INSERT));
        push_change(change_word(f, f, $urandom, KIND_UPDATE));
        push_change(change_word(f, f, $urandom, KIND_DELETE));
        push_change(change_word(ent_pool[1], fld_pool[0], $urandom, KIND_DELETE));
        // cancel of the last entry itself
        push_change(change_word(f, z, $urandom, KIND_INSERT));
        push_change(change_word(f, z, $urandom, KIND_DELETE));

        random_phase(4, 4, 0, 1, 4, 3, 3, 12, 12, 250);
        random_phase(4, 4, 0, 1, 4, 3, 3, 0, 0, 150);
        random_phase(12, 8, 0, 1, 6, 3, 1, 0, 0, 250);
        random_phase(12, 8, 0, 1, 3, 3, 3, 12, 0, 200);
        random_phase(16, 16, 25, 1, 5, 2, 2, 0, 12, 200);
        random_phase(16, 16, 0, 1, 5, 0, 5, 12, 12, 250);
        random_phase(6, 6, 5, 1, 5, 3, 3, 6, 6, 150);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (ledger.outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d changes checked: %0d ok, %0d kind none, %0d lifecycle rejects, %0d full",
                 ledger.checked, ledger.status_cnt[ST_OK], ledger.status_cnt[ST_BAD_ARG],
                 ledger.status_cnt[ST_BAD_STATE], ledger.status_cnt[ST_FULL]);
        $display("table peaked at %0d of %0d entries, final revision %0d, %0d mismatches",
                 ledger.peak, TABLE_DEPTH, ledger.rev, ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/crt_pkg.sv
design/crt_ram.sv
design/change_record_table_top.sv
test/tb_top.sv
